>>> design/gmc_pkg.sv
package gmc_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int X_W        = $clog2(MAX_WIDTH);
  localparam int Y_W        = $clog2(MAX_HEIGHT);
  localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
  localparam int STK_AW     = $clog2(CELLS);
  localparam int DEPTH_W    = $clog2(CELLS + 1);
  localparam int DIM_W      = 7;

  // configuration register indexes
  localparam logic [0:0] CFG_GRID_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_t;

  typedef enum logic [1:0] {
    KIND_CARVE  = 2'd0,
    KIND_REJECT = 2'd1,
    KIND_BACK   = 2'd2,
    KIND_DONE   = 2'd3
  } kind_t;

  // request bundle into the visited map
  typedef struct packed {
    logic                 rd_en;
    logic [Y_W-1:0]       rd_addr;
    logic                 wr_en;
    logic [Y_W-1:0]       wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;
    logic                 clr;
  } map_req_t;

endpackage

>>> design/gmc_visit_map.sv
// Visited map, one row of cells per entry. Per-row valid flops make a
// cleared map immediate: an invalid row reads as all zero.
module gmc_visit_map (
  input  logic                          clk,
  input  logic                          rst,
  input  gmc_pkg::map_req_t             req,
  output logic [gmc_pkg::MAX_WIDTH-1:0] rd_row
);

  logic [gmc_pkg::MAX_WIDTH-1:0]  mem [gmc_pkg::MAX_HEIGHT];
  logic [gmc_pkg::MAX_HEIGHT-1:0] row_valid, row_valid_next;
  logic [gmc_pkg::MAX_WIDTH-1:0]  rd_q;
  logic                           rd_vq;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  // clear first, then mark the row being written
  always_comb begin
    row_valid_next = req.clr ? '0 : row_valid;
    if (req.wr_en) begin
      row_valid_next[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      rd_vq     <= 1'b0;
    end else begin
      row_valid <= row_valid_next;
      if (req.rd_en) begin
        rd_vq <= row_valid[req.rd_addr];
      end
    end
  end

  assign rd_row = rd_vq ? rd_q : '0;

endmodule

>>> design/grid_maze_dfs_carver_unit.sv
// Depth-first maze carver. One input beat is one command, one output beat
// is its single result.
//   s_* : command beats. s_tuser = mode (1 starts a new maze at (0,0),
//         0 takes one walk step), s_tdata[1:0] = random direction try.
//   m_* : result beats. m_tuser = kind (carved, rejected, backtracked,
//         finished/started); m_tdata holds cell x, cell y and wall side.
//   cfg_* : width (index 0) and height (index 1) of the grid in use, to be
//         written only while the block is idle (the block does not enforce it).
// Timing: a walk step reads the top of the cell stack, then the rows
// y, y-1 and y+1 of the visited map, one memory read per cycle, and
// writes back in the decide cycle. The result register loads as the
// decide state ends; a start or an empty stack goes there straight after
// the stack read. The next command is taken only once the block is back
// in idle, so commands do not overlap. The single read port of each
// memory sets this sequence.
// Reset: stack empty, map cleared, sizes 16 x 16; a step before any
// start reports finished. The result register frees the input side; if
// the receiver stalls, the next command is accepted and worked up to the
// decide cycle, which waits there with no state change until the pending
// beat is taken.
module grid_maze_dfs_carver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] rand_dir, rest zero
  input  logic [0:0]  s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [5:0] cell_x, [11:6] cell_y, [13:12] wall_dir, rest zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [6:0]  cfg_wdata
);

  localparam int XW = gmc_pkg::X_W;
  localparam int YW = gmc_pkg::Y_W;
  localparam int DW = gmc_pkg::DEPTH_W;
  localparam int AW = gmc_pkg::STK_AW;
  localparam int MW = gmc_pkg::MAX_WIDTH;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_TOP  = 6'b000010,  // stack top read issued
    ST_ROWC = 6'b000100,  // top arrives, read row y
    ST_ROWU = 6'b001000,  // row y arrives, read row y-1
    ST_ROWD = 6'b010000,  // row y-1 arrives, read row y+1
    ST_DEC  = 6'b100000   // row y+1 arrives, decide and write back
  } state_t;

  state_t state, state_next;

  // config
  logic [gmc_pkg::DIM_W-1:0] grid_width, grid_height;
  logic [gmc_pkg::DIM_W-1:0] w_eff, h_eff;

  // walk state
  logic [DW-1:0] depth;
  logic          top_fresh;

  // per-command latches
  logic          mode_q;
  logic [1:0]    rdir_q;
  logic [XW-1:0] top_x;
  logic [YW-1:0] top_y;
  logic [MW-1:0] row_c, row_u;

  // memories
  logic [XW+YW-1:0] stk_mem [gmc_pkg::CELLS];
  logic [XW+YW-1:0] stk_q;
  logic             stk_re, stk_we;
  logic [AW-1:0]    stk_raddr, stk_waddr;
  logic [XW+YW-1:0] stk_wdata;

  gmc_pkg::map_req_t map_req;
  logic [MW-1:0]     map_rd;

  // decide
  logic          out_free, dec_go;
  logic [3:0]    ok;
  logic          any_ok, do_start, do_empty, do_pop, do_reject, do_carve;
  gmc_pkg::dir_t first_dir, carve_dir;
  gmc_pkg::kind_t res_kind;
  logic [1:0]    res_dir;
  logic [XW-1:0] res_x, nx, xm1, xp1;
  logic [YW-1:0] res_y, ny, ym1, yp1;
  logic [MW-1:0] tgt_row;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign dec_go   = (state == ST_DEC) && out_free;

  // sizes out of range clamp to 1..max
  always_comb begin
    if (grid_width == '0) begin
      w_eff = gmc_pkg::DIM_W'(1);
    end else if (grid_width > gmc_pkg::DIM_W'(gmc_pkg::MAX_WIDTH)) begin
      w_eff = gmc_pkg::DIM_W'(gmc_pkg::MAX_WIDTH);
    end else begin
      w_eff = grid_width;
    end
    if (grid_height == '0) begin
      h_eff = gmc_pkg::DIM_W'(1);
    end else if (grid_height > gmc_pkg::DIM_W'(gmc_pkg::MAX_HEIGHT)) begin
      h_eff = gmc_pkg::DIM_W'(gmc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = grid_height;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= gmc_pkg::DIM_W'(16);
      grid_height <= gmc_pkg::DIM_W'(16);
    end else if (cfg_we) begin
      case (cfg_addr)
        gmc_pkg::CFG_GRID_WIDTH:  grid_width  <= cfg_wdata;
        gmc_pkg::CFG_GRID_HEIGHT: grid_height <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // neighbor checks: in grid and not yet visited
  assign xm1 = top_x - XW'(1);
  assign xp1 = top_x + XW'(1);
  assign ym1 = top_y - YW'(1);
  assign yp1 = top_y + YW'(1);

  always_comb begin
    ok[gmc_pkg::DIR_UP]    = (top_y != '0) && !row_u[top_x];
    ok[gmc_pkg::DIR_DOWN]  = ((gmc_pkg::DIM_W'(top_y) + gmc_pkg::DIM_W'(1)) < h_eff)
                             && !map_rd[top_x];
    ok[gmc_pkg::DIR_LEFT]  = (top_x != '0) && !row_c[xm1];
    ok[gmc_pkg::DIR_RIGHT] = ((gmc_pkg::DIM_W'(top_x) + gmc_pkg::DIM_W'(1)) < w_eff)
                             && !row_c[xp1];
  end

  assign any_ok = |ok;

  always_comb begin
    if (ok[gmc_pkg::DIR_UP]) begin
      first_dir = gmc_pkg::DIR_UP;
    end else if (ok[gmc_pkg::DIR_DOWN]) begin
      first_dir = gmc_pkg::DIR_DOWN;
    end else if (ok[gmc_pkg::DIR_LEFT]) begin
      first_dir = gmc_pkg::DIR_LEFT;
    end else begin
      first_dir = gmc_pkg::DIR_RIGHT;
    end
  end

  always_comb begin
    do_start  = mode_q;
    do_empty  = !mode_q && ((depth == '0) || (depth > DW'(gmc_pkg::CELLS)));
    do_pop    = !mode_q && !do_empty && (!any_ok || (depth >= DW'(gmc_pkg::CELLS)));
    do_reject = !mode_q && !do_empty && !do_pop && top_fresh && !ok[rdir_q];
    do_carve  = !mode_q && !do_empty && !do_pop && !do_reject;
    carve_dir = top_fresh ? gmc_pkg::dir_t'(rdir_q) : first_dir;
  end

  // carve target cell and the row it lives in
  always_comb begin
    nx      = top_x;
    ny      = top_y;
    tgt_row = row_c;
    case (carve_dir)
      gmc_pkg::DIR_UP: begin
        ny      = ym1;
        tgt_row = row_u;
      end
      gmc_pkg::DIR_DOWN: begin
        ny      = yp1;
        tgt_row = map_rd;
      end
      gmc_pkg::DIR_LEFT:  nx = xm1;
      gmc_pkg::DIR_RIGHT: nx = xp1;
      default: ;
    endcase
  end

  always_comb begin
    res_kind = gmc_pkg::KIND_DONE;
    res_x    = '0;
    res_y    = '0;
    res_dir  = gmc_pkg::DIR_UP;
    if (do_pop) begin
      res_kind = gmc_pkg::KIND_BACK;
      res_x    = top_x;
      res_y    = top_y;
    end else if (do_reject) begin
      res_kind = gmc_pkg::KIND_REJECT;
      res_x    = top_x;
      res_y    = top_y;
      res_dir  = rdir_q;
    end else if (do_carve) begin
      res_kind = gmc_pkg::KIND_CARVE;
      res_x    = top_x;
      res_y    = top_y;
      res_dir  = carve_dir;
    end
  end

  // memory requests
  always_comb begin
    stk_re    = (state == ST_TOP);
    stk_raddr = AW'(depth - DW'(1));
    stk_we    = dec_go && (do_start || do_carve);
    stk_waddr = do_start ? '0 : depth[AW-1:0];
    stk_wdata = do_start ? '0 : {ny, nx};

    map_req         = '0;
    map_req.rd_en   = (state == ST_ROWC) || (state == ST_ROWU) || (state == ST_ROWD);
    map_req.rd_addr = stk_q[XW+YW-1:XW];
    if (state == ST_ROWU) begin
      map_req.rd_addr = ym1;
    end else if (state == ST_ROWD) begin
      map_req.rd_addr = yp1;
    end
    map_req.clr     = dec_go && do_start;
    map_req.wr_en   = dec_go && (do_start || do_carve);
    map_req.wr_addr = do_start ? '0 : ny;
    map_req.wr_data = do_start ? MW'(1) : (tgt_row | (MW'(1) << nx));
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_q <= stk_mem[stk_raddr];
    end
  end

  gmc_visit_map u_map (
    .clk    (clk),
    .rst    (rst),
    .req    (map_req),
    .rd_row (map_rd)
  );

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_tvalid) state_next = ST_TOP;
      ST_TOP: begin
        if (mode_q || (depth == '0) || (depth > DW'(gmc_pkg::CELLS))) begin
          state_next = ST_DEC;
        end else begin
          state_next = ST_ROWC;
        end
      end
      ST_ROWC: state_next = ST_ROWU;
      ST_ROWU: state_next = ST_ROWD;
      ST_ROWD: state_next = ST_DEC;
      ST_DEC:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      depth     <= '0;
      top_fresh <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state <= state_next;
      if (dec_go) begin
        m_tvalid <= 1'b1;
        if (do_start) begin
          depth     <= DW'(1);
          top_fresh <= 1'b1;
        end else if (do_empty) begin
          depth <= '0;
        end else if (do_pop) begin
          depth     <= depth - DW'(1);
          top_fresh <= 1'b0;
        end else if (do_carve) begin
          depth     <= depth + DW'(1);
          top_fresh <= 1'b1;
        end
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload latches
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      mode_q <= s_tuser[0];
      rdir_q <= s_tdata[1:0];
    end
    if (state == ST_ROWC) begin
      top_x <= stk_q[XW-1:0];
      top_y <= stk_q[XW+YW-1:XW];
    end
    if (state == ST_ROWU) begin
      row_c <= map_rd;
    end
    if (state == ST_ROWD) begin
      row_u <= map_rd;
    end
    if (dec_go) begin
      m_tuser <= res_kind;
      m_tdata <= {2'b00, res_dir, res_y, res_x};
    end
  end

endmodule

>>> tb/sv/grid_maze_dfs_carver_unit_tb.sv
`timescale 1ns / 100ps

// Depth-first maze carver bench: drives command beats (start / walk step),
// predicts every result beat with a cycle-free model of the walk, and
// checks result beats in order against that prediction.
module grid_maze_dfs_carver_unit_tb;

  localparam int STALL_LIMIT = 5000;  // cycles with no beat on either side
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int ITEM_GOAL   = 1200;
  localparam int PHASE_CAP   = 150;   // steps per maze before moving on
  localparam int DRAIN_WAIT  = 8;     // outlasts a step from accept to its result

  // Walk predictor and result scoreboard in one.
  class carve_scoreboard;
    typedef struct {
      gmc_pkg::kind_t          kind;
      logic [gmc_pkg::X_W-1:0] x;
      logic [gmc_pkg::Y_W-1:0] y;
      gmc_pkg::dir_t           wall;
    } move_rec_t;

    bit [gmc_pkg::MAX_WIDTH-1:0] visited [gmc_pkg::MAX_HEIGHT];
    int unsigned                 stk_x [gmc_pkg::CELLS];
    int unsigned                 stk_y [gmc_pkg::CELLS];
    int unsigned                 depth;
    bit                          fresh;
    bit                          done;
    bit [gmc_pkg::DIM_W-1:0]     width_reg;
    bit [gmc_pkg::DIM_W-1:0]     height_reg;
    move_rec_t                   expected_moves [$];
    int unsigned                 errors;

    function new();
      foreach (visited[i]) visited[i] = '0;
      depth      = 0;
      fresh      = 1'b0;
      done       = 1'b1;
      width_reg  = gmc_pkg::DIM_W'(16);
      height_reg = gmc_pkg::DIM_W'(16);
      errors     = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [gmc_pkg::DIM_W-1:0] val);
      if (idx == gmc_pkg::CFG_GRID_WIDTH) width_reg = val;
      else height_reg = val;
    endfunction

    // neighbor in grid and not yet visited
    function bit open_side(int unsigned x, int unsigned y, gmc_pkg::dir_t d,
                           int unsigned w, int unsigned h);
      int unsigned nx, ny;
      nx = x;
      ny = y;
      case (d)
        gmc_pkg::DIR_UP: begin
          if (y == 0) return 1'b0;
          ny = y - 1;
        end
        gmc_pkg::DIR_DOWN: begin
          if (y + 1 >= h) return 1'b0;
          ny = y + 1;
        end
        gmc_pkg::DIR_LEFT: begin
          if (x == 0) return 1'b0;
          nx = x - 1;
        end
        default: begin
          if (x + 1 >= w) return 1'b0;
          nx = x + 1;
        end
      endcase
      if (nx >= gmc_pkg::MAX_WIDTH || ny >= gmc_pkg::MAX_HEIGHT) return 1'b0;
      return !visited[ny][nx];
    endfunction

    function void note_cmd(bit mode, gmc_pkg::dir_t rdir);
      int unsigned   w, h, x, y, nx, ny;
      bit            any;
      gmc_pkg::dir_t d;
      move_rec_t     r;
      // zero acts as one, oversize acts as the maximum
      w = (width_reg == 0) ? 1 :
          ((width_reg > gmc_pkg::MAX_WIDTH) ? gmc_pkg::MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 :
          ((height_reg > gmc_pkg::MAX_HEIGHT) ? gmc_pkg::MAX_HEIGHT : height_reg);
      r.x    = '0;
      r.y    = '0;
      r.wall = gmc_pkg::DIR_UP;
      if (mode) begin
        foreach (visited[i]) visited[i] = '0;
        visited[0][0] = 1'b1;
        stk_x[0] = 0;
        stk_y[0] = 0;
        depth    = 1;
        fresh    = 1'b1;
        done     = 1'b0;
        r.kind   = gmc_pkg::KIND_DONE;
        expected_moves.push_back(r);
        return;
      end
      if (depth == 0 || depth > gmc_pkg::CELLS) begin
        depth  = 0;
        done   = 1'b1;
        r.kind = gmc_pkg::KIND_DONE;
        expected_moves.push_back(r);
        return;
      end
      x   = stk_x[depth-1];
      y   = stk_y[depth-1];
      r.x = gmc_pkg::X_W'(x);
      r.y = gmc_pkg::Y_W'(y);
      any = 1'b0;
      for (int i = 0; i < 4; i++)
        if (open_side(x, y, gmc_pkg::dir_t'(i), w, h)) any = 1'b1;
      // dead end (or full stack guard): pop
      if (!any || depth >= gmc_pkg::CELLS) begin
        depth--;
        fresh  = 1'b0;
        r.kind = gmc_pkg::KIND_BACK;
        expected_moves.push_back(r);
        return;
      end
      if (fresh) begin
        if (!open_side(x, y, rdir, w, h)) begin
          r.kind = gmc_pkg::KIND_REJECT;
          r.wall = rdir;
          expected_moves.push_back(r);
          return;
        end
        d = rdir;
      end else begin
        // returned-to cell: first open side in up, down, left, right order
        d = gmc_pkg::DIR_UP;
        for (int i = 3; i >= 0; i--)
          if (open_side(x, y, gmc_pkg::dir_t'(i), w, h)) d = gmc_pkg::dir_t'(i);
      end
      nx = x;
      ny = y;
      case (d)
        gmc_pkg::DIR_UP:   ny = y - 1;
        gmc_pkg::DIR_DOWN: ny = y + 1;
        gmc_pkg::DIR_LEFT: nx = x - 1;
        default:           nx = x + 1;
      endcase
      visited[ny][nx] = 1'b1;
      stk_x[depth] = nx;
      stk_y[depth] = ny;
      depth++;
      fresh  = 1'b1;
      r.kind = gmc_pkg::KIND_CARVE;
      r.wall = d;
      expected_moves.push_back(r);
    endfunction

    function void check_result(logic [1:0] kind, logic [15:0] data);
      move_rec_t               e;
      logic [gmc_pkg::X_W-1:0] ax;
      logic [gmc_pkg::Y_W-1:0] ay;
      logic [1:0]              aw;
      ax = data[5:0];
      ay = data[11:6];
      aw = data[13:12];
      if (expected_moves.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat, got kind %0d x %0d y %0d wall %0d",
                 $time, kind, ax, ay, aw);
        return;
      end
      e = expected_moves.pop_front();
      if (kind !== e.kind || ax !== e.x || ay !== e.y || aw !== e.wall) begin
        errors++;
        $display({"%0t: mismatch, exp kind %0d x %0d y %0d wall %0d, ",
                  "got kind %0d x %0d y %0d wall %0d"},
                 $time, e.kind, e.x, e.y, e.wall, kind, ax, ay, aw);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;    // [1:0] rand_dir, rest zero
  logic [0:0]  s_tuser = '0;    // [0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;         // [5:0] cell_x, [11:6] cell_y, [13:12] wall_dir
  logic [1:0]  m_tuser;         // [1:0] kind
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_addr = '0;
  logic [6:0]  cfg_wdata = '0;

  carve_scoreboard sb = new();
  int unsigned     idle_pct = 30;    // shared by both sides
  bit              hold_req = 1'b0;  // asks the receiver for a long hold-off
  int unsigned     n_sent = 0;

  grid_maze_dfs_carver_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // One command beat. tvalid stays up into the next call when there is no
  // gap, so it is never dropped and raised in the same step.
  task automatic send_cmd(bit mode, gmc_pkg::dir_t rdir);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {6'b0, rdir};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_cmd(mode, rdir);
    n_sent++;
  endtask

  task automatic write_reg(logic [0:0] idx, logic [6:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, drain every pending result, then let the pipe go quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Receiver: checks each accepted result beat, then picks next tready.
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // Watchdog: no beat on either side for too long means a hang.
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int unsigned phase, steps, pick;
    logic [6:0]  w, h;
    bit          resume;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // step before any start: reports finished
    send_cmd(1'b0, gmc_pkg::DIR_RIGHT);
    settle();
    // zero width acts as one: 1x1 maze, pop then finished twice
    write_reg(gmc_pkg::CFG_GRID_WIDTH, 7'd0);
    write_reg(gmc_pkg::CFG_GRID_HEIGHT, 7'd1);
    send_cmd(1'b1, gmc_pkg::DIR_DOWN);
    send_cmd(1'b0, gmc_pkg::DIR_LEFT);
    send_cmd(1'b0, gmc_pkg::DIR_UP);
    send_cmd(1'b0, gmc_pkg::DIR_RIGHT);
    settle();
    // 2x2: rejected tries, carves, backtracks, returned-to cells
    write_reg(gmc_pkg::CFG_GRID_WIDTH, 7'd2);
    write_reg(gmc_pkg::CFG_GRID_HEIGHT, 7'd2);
    send_cmd(1'b1, gmc_pkg::DIR_RIGHT);
    for (int i = 0; i < 10; i++) send_cmd(1'b0, gmc_pkg::dir_t'(i % 4));
    settle();
    // oversize width clamps to the max, height at the max
    write_reg(gmc_pkg::CFG_GRID_WIDTH, 7'd127);
    write_reg(gmc_pkg::CFG_GRID_HEIGHT, 7'd64);
    send_cmd(1'b1, gmc_pkg::DIR_LEFT);
    send_cmd(1'b0, gmc_pkg::DIR_UP);
    send_cmd(1'b0, gmc_pkg::DIR_LEFT);
    send_cmd(1'b0, gmc_pkg::DIR_RIGHT);
    send_cmd(1'b0, gmc_pkg::DIR_DOWN);

    // --- random mazes, mostly small ---
    phase = 0;
    while (n_sent < ITEM_GOAL) begin
      settle();
      // a run of phases with no idling on either side
      idle_pct = (phase >= 6 && phase < 10) ? 0 : 30;
      pick = $urandom_range(99);
      if (phase == 2) begin
        w = 7'd8;
        h = 7'd8;
      end else if (pick < 80) begin
        w = 7'($urandom_range(1, 8));
        h = 7'($urandom_range(1, 8));
      end else if (pick < 92) begin
        w = 7'($urandom_range(0, 20));
        h = 7'($urandom_range(0, 20));
      end else begin
        w = 7'($urandom_range(60, 127));
        h = 7'($urandom_range(0, 127));
      end
      if ($urandom_range(3) != 0) begin
        write_reg(gmc_pkg::CFG_GRID_WIDTH, w);
        write_reg(gmc_pkg::CFG_GRID_HEIGHT, h);
      end else if ($urandom_range(1)) begin
        write_reg(gmc_pkg::CFG_GRID_WIDTH, w);
      end else begin
        write_reg(gmc_pkg::CFG_GRID_HEIGHT, h);
      end
      // now and then keep the old walk going under the new sizes
      resume = (phase % 7 == 3) && !sb.done;
      if (!resume) send_cmd(1'b1, gmc_pkg::dir_t'($urandom_range(3)));
      // receiver holds off while commands keep coming
      if (phase == 2) hold_req = 1'b1;
      steps = 0;
      while (steps < PHASE_CAP && !sb.done) begin
        // rare restart in the middle of a walk
        if ($urandom_range(99) < 2) send_cmd(1'b1, gmc_pkg::dir_t'($urandom_range(3)));
        else send_cmd(1'b0, gmc_pkg::dir_t'($urandom_range(3)));
        steps++;
      end
      // steps on a finished maze
      repeat ($urandom_range(0, 2)) send_cmd(1'b0, gmc_pkg::dir_t'($urandom_range(3)));
      phase++;
    end

    settle();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
